>>> rtl/csa_pkg.sv
`timescale 1ns / 1ps

package csa_pkg;

  localparam int COORD_W = 64;
  localparam int INDEX_W = 4;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } sum_t;

  typedef enum logic [3:0] {
    ST_RUN  = 4'b0001,
    ST_READ = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_SEND = 4'b1000
  } state_t;

endpackage

>>> rtl/csa_ram.sv
`timescale 1ns / 1ps

module csa_ram #(
  parameter int WIDTH = 192,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/centroid_sum_accumulator.sv
`timescale 1ns / 1ps

// Channel  Signals                                      Direction
// -------  -------------------------------------------  ---------
// in       in_valid/in_ready, centroid_index, point_*   sink
// out      out_valid/out_ready, sum_index, sum_*,       source
//          last_of_run
//
// Points are accumulated at one transaction per cycle outside a dump: a read
// of the sum memory, an add in the following cycle with the write back, and
// a one-entry bypass for back-to-back points to the same centroid.
// A point for the last centroid starts a dump of all CENTROID_COUNT sums,
// each read, loaded and sent when out_ready; input is held off meanwhile.
// Reset clears the sums at once through one valid bit per entry.
// Output stalls never block accumulation outside a dump.

module centroid_sum_accumulator #(
  parameter int CENTROID_COUNT = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [csa_pkg::INDEX_W-1:0]          centroid_index,
  input  logic signed [csa_pkg::COORD_W-1:0]   point_x,
  input  logic signed [csa_pkg::COORD_W-1:0]   point_y,
  input  logic signed [csa_pkg::COORD_W-1:0]   point_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [csa_pkg::INDEX_W-1:0]          sum_index,
  output logic signed [csa_pkg::COORD_W-1:0]   sum_x,
  output logic signed [csa_pkg::COORD_W-1:0]   sum_y,
  output logic signed [csa_pkg::COORD_W-1:0]   sum_z,
  output logic                                 last_of_run
);

  import csa_pkg::*;

  localparam int AW = (CENTROID_COUNT > 1) ? $clog2(CENTROID_COUNT) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(CENTROID_COUNT - 1);

  state_t state, state_next;

  logic                      in_fire;
  logic                      in_ok;
  logic                      in_last;
  logic [AW-1:0]             in_addr;

  logic                      s1_valid;
  logic                      s1_last;
  logic                      s1_fwd;
  logic [AW-1:0]             s1_addr;
  sum_t                      s1_point;

  sum_t                      wr_sum;
  sum_t                      base_sum;
  sum_t                      new_sum;
  sum_t                      rd_data;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;

  logic [CENTROID_COUNT-1:0] entry_valid;
  logic [AW-1:0]             dump_addr;

  sum_t                      out_sum;
  logic [AW-1:0]             out_addr;

  // Indices past the store are accepted and dropped.
  assign in_addr  = AW'(centroid_index);
  assign in_ok    = (32'(centroid_index) < 32'(CENTROID_COUNT));
  assign in_last  = (32'(centroid_index) == 32'(CENTROID_COUNT - 1));
  assign in_ready = (state == ST_RUN) && !(s1_valid && s1_last);
  assign in_fire  = in_valid && in_ready;

  assign rd_en   = (in_fire && in_ok) || (state == ST_READ);
  assign rd_addr = (state == ST_READ) ? dump_addr : in_addr;

  csa_ram #(
    .WIDTH ($bits(sum_t)),
    .DEPTH (CENTROID_COUNT)
  ) u_sum_ram (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_addr),
    .wr_data (new_sum),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The write of the previous point lands after this point's read was issued,
  // so a match on the same centroid takes the sum from the bypass register.
  always_comb begin
    if (s1_fwd) begin
      base_sum = wr_sum;
    end else if (entry_valid[s1_addr]) begin
      base_sum = rd_data;
    end else begin
      base_sum = '0;
    end
    new_sum.x = base_sum.x + s1_point.x;
    new_sum.y = base_sum.y + s1_point.y;
    new_sum.z = base_sum.z + s1_point.z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire && in_ok;
    end
    if (in_fire) begin
      s1_addr    <= in_addr;
      s1_last    <= in_last;
      s1_fwd     <= s1_valid && (s1_addr == in_addr);
      s1_point.x <= point_x;
      s1_point.y <= point_y;
      s1_point.z <= point_z;
    end
    if (s1_valid) begin
      wr_sum <= new_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (s1_valid) begin
      entry_valid[s1_addr] <= 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (s1_valid && s1_last) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (out_ready) begin
          state_next = (dump_addr == LAST_ADDR) ? ST_RUN : ST_READ;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      dump_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_RUN) begin
        dump_addr <= '0;
      end else if (state == ST_SEND && out_ready) begin
        dump_addr <= dump_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      out_sum  <= entry_valid[dump_addr] ? rd_data : '0;
      out_addr <= dump_addr;
    end
  end

  assign out_valid   = (state == ST_SEND);
  assign sum_index   = INDEX_W'(out_addr);
  assign sum_x       = out_sum.x;
  assign sum_y       = out_sum.y;
  assign sum_z       = out_sum.z;
  assign last_of_run = (out_addr == LAST_ADDR);

`ifndef SYNTHESIS
  a_no_accept_before_dump: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready && s1_valid && s1_last))
    else $error("input transaction accepted while a dump is pending");

  a_dump_starts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && s1_valid && s1_last) |=> (state == ST_READ))
    else $error("last-centroid point did not start a dump");

  a_dump_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_of_run) |=> (state == ST_RUN))
    else $error("dump did not end after the final sum");

  a_dump_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_of_run) |=> ##2
      (out_valid && out_addr == $past(out_addr, 3) + AW'(1)))
    else $error("dump sums out of order");
`endif

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import csa_pkg::*;

  localparam int CENTROID_COUNT = 16;
  localparam logic [INDEX_W-1:0] LAST_CENTROID = INDEX_W'(CENTROID_COUNT - 1);
  localparam logic [COORD_W-1:0] COORD_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [COORD_W-1:0] COORD_MIN = 64'h8000_0000_0000_0000;
  localparam logic [COORD_W-1:0] COORD_NEG_ONE = '1;
  localparam int IDLE_PCT = 13;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [INDEX_W-1:0] idx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } point_item_t;

  typedef struct {
    logic [INDEX_W-1:0] idx;
    sum_t               sums;
    logic               last;
  } sum_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [INDEX_W-1:0] centroid_index = '0;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic signed [COORD_W-1:0] point_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [INDEX_W-1:0] sum_index;
  logic signed [COORD_W-1:0] sum_x;
  logic signed [COORD_W-1:0] sum_y;
  logic signed [COORD_W-1:0] sum_z;
  logic last_of_run;

  point_item_t pending_points[$];
  sum_result_t expected_sums[$];
  sum_t        running_sums[CENTROID_COUNT];
  point_item_t next_point;
  sum_result_t head_sum;
  logic        in_taken = 1'b0;
  int          points_sent = 0;
  int          results_seen = 0;
  int          error_count = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  centroid_sum_accumulator #(
    .CENTROID_COUNT(CENTROID_COUNT)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .centroid_index(centroid_index),
    .point_x       (point_x),
    .point_y       (point_y),
    .point_z       (point_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sum_index     (sum_index),
    .sum_x         (sum_x),
    .sum_y         (sum_y),
    .sum_z         (sum_z),
    .last_of_run   (last_of_run)
  );

  always #4 clk = ~clk;

  // Adds one point to its centroid and, for the last centroid, queues the
  // whole dump of sums in index order.
  task automatic add_point(input logic [INDEX_W-1:0] idx, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
    sum_result_t r;
    running_sums[idx].x = running_sums[idx].x + x;
    running_sums[idx].y = running_sums[idx].y + y;
    running_sums[idx].z = running_sums[idx].z + z;
    if (idx == LAST_CENTROID) begin
      for (int k = 0; k < CENTROID_COUNT; k++) begin
        r.idx  = INDEX_W'(k);
        r.sums = running_sums[k];
        r.last = (k == CENTROID_COUNT - 1);
        expected_sums.push_back(r);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [COORD_W-1:0] exp_v,
                             input logic [COORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    int unsigned pick;
    pick = $urandom_range(9);
    case (pick)
      0: rand_coord = COORD_MAX;
      1: rand_coord = COORD_MIN;
      2: rand_coord = COORD_NEG_ONE;
      3: rand_coord = COORD_W'($urandom_range(15));
      default: rand_coord = {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_point(input logic [INDEX_W-1:0] idx, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
    point_item_t p;
    p.idx = idx;
    p.x   = x;
    p.y   = y;
    p.z   = z;
    pending_points.push_back(p);
  endtask

  // Driver: offers the next pending point once the current transaction is done.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_points.size() != 0 &&
          ((points_sent >= 40 && points_sent < 75) || $urandom_range(99) >= IDLE_PCT)) begin
        next_point = pending_points.pop_front();
        in_valid <= 1'b1;
        centroid_index <= next_point.idx;
        point_x <= next_point.x;
        point_y <= next_point.y;
        point_z <= next_point.z;
        points_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off in the middle of a dump, and a
  // stretch with no stalls at all.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= 40) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (results_seen >= 100 && results_seen < 220) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: updates the prediction on each accepted point and checks each
  // accepted sum against the oldest expected one.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        add_point(centroid_index, point_x, point_y, point_z);
      end
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: unexpected sum transaction, expected none, actual index %0d",
                   $time, sum_index);
          error_count++;
        end else begin
          head_sum = expected_sums.pop_front();
          check_field("sum_index", COORD_W'(head_sum.idx), COORD_W'(sum_index));
          check_field("sum_x", head_sum.sums.x, sum_x);
          check_field("sum_y", head_sum.sums.y, sum_y);
          check_field("sum_z", head_sum.sums.z, sum_z);
          check_field("last_of_run", COORD_W'(head_sum.last), COORD_W'(last_of_run));
        end
        results_seen++;
      end
    end
  end

  initial begin
    logic [INDEX_W-1:0] idx;
    logic [INDEX_W-1:0] prev_idx;

    for (int k = 0; k < CENTROID_COUNT; k++) begin
      running_sums[k] = '0;
    end

    // Wrap in both directions on one centroid, queued back to back.
    queue_point(4'd0, COORD_MAX, COORD_MIN, COORD_NEG_ONE);
    queue_point(4'd0, 64'd1, COORD_NEG_ONE, 64'd1);
    // Two dumps in a row, the second wrapping the last centroid's sums.
    queue_point(LAST_CENTROID, COORD_MAX, COORD_MAX, COORD_MAX);
    queue_point(LAST_CENTROID, 64'd1, 64'd1, 64'd1);
    for (int k = 1; k < CENTROID_COUNT - 1; k++) begin
      queue_point(INDEX_W'(k), COORD_MIN, COORD_W'(k), COORD_NEG_ONE - COORD_W'(k));
    end
    queue_point(LAST_CENTROID, '0, '0, '0);

    // Random rounds: points to mostly random centroids, often repeating the
    // previous centroid, with a dump roughly every sixth point.
    prev_idx = '0;
    for (int n = 0; n < 90; n++) begin
      if ($urandom_range(5) == 0) begin
        idx = LAST_CENTROID;
      end else if ($urandom_range(3) == 0) begin
        idx = prev_idx;
      end else begin
        idx = INDEX_W'($urandom_range(CENTROID_COUNT - 2));
      end
      queue_point(idx, rand_coord(), rand_coord(), rand_coord());
      prev_idx = idx;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_points.size() != 0 || in_valid) @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("** centroid_sum_accumulator: PASSED **");
    end else begin
      $display("** centroid_sum_accumulator: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** centroid_sum_accumulator: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
rtl/csa_pkg.sv
rtl/csa_ram.sv
rtl/centroid_sum_accumulator.sv
tb/sv/tb_top.sv
